### src/sgpa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgpa_pkg
// Shared types, constants and trig table for the projection accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package sgpa_pkg;

    localparam int DEF_NODE_COUNT = 1024;
    localparam int DEF_BAND_COUNT = 9;
    localparam int GRID_SIDE      = 32;

    localparam int IDX_W   = 10;
    localparam int BAND_W  = 4;
    localparam int CFG_W   = 11;
    localparam int COEF_W  = 32;
    localparam int SMP_W   = 16;

    localparam logic signed [20:0] K_Y00   = 21'sd4622;
    localparam logic signed [20:0] K_L1    = 21'sd8005;
    localparam logic signed [20:0] K_L2A   = 21'sd17900;
    localparam logic signed [20:0] K_L2B   = 21'sd35801;
    localparam logic signed [17:0] K_THIRD = 18'sd5461;
    localparam logic signed [17:0] K_SCALE = 18'sd6554;
    localparam logic signed [17:0] K_ONE   = 18'sd16384;

    localparam logic [2:0] ADDR_ACTIVE_NODES = 3'd0;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SCALE, ST_A1, ST_B1, ST_B2,
        ST_C1, ST_C2, ST_CC, ST_Y, ST_INC, ST_ACC
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_SCALE, OP_A1, OP_B1, OP_B2,
        OP_C1, OP_C2, OP_CC, OP_Y, OP_INC, OP_ACC
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [BAND_W-1:0] band;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

    // sin(m*pi/32) in q1.14, m modulo 64
    function automatic logic signed [17:0] sin_at(input logic [5:0] m);
        logic [14:0] v;
        case (m[4:0])
            5'd0:  v = 15'd0;     5'd1:  v = 15'd1606;  5'd2:  v = 15'd3196;
            5'd3:  v = 15'd4756;  5'd4:  v = 15'd6270;  5'd5:  v = 15'd7723;
            5'd6:  v = 15'd9102;  5'd7:  v = 15'd10394; 5'd8:  v = 15'd11585;
            5'd9:  v = 15'd12665; 5'd10: v = 15'd13623; 5'd11: v = 15'd14449;
            5'd12: v = 15'd15137; 5'd13: v = 15'd15679; 5'd14: v = 15'd16069;
            5'd15: v = 15'd16305; 5'd16: v = 15'd16384; 5'd17: v = 15'd16305;
            5'd18: v = 15'd16069; 5'd19: v = 15'd15679; 5'd20: v = 15'd15137;
            5'd21: v = 15'd14449; 5'd22: v = 15'd13623; 5'd23: v = 15'd12665;
            5'd24: v = 15'd11585; 5'd25: v = 15'd10394; 5'd26: v = 15'd9102;
            5'd27: v = 15'd7723;  5'd28: v = 15'd6270;  5'd29: v = 15'd4756;
            5'd30: v = 15'd3196;  5'd31: v = 15'd1606;
            default: v = 15'd0;
        endcase
        return m[5] ? -$signed({3'b000, v}) : $signed({3'b000, v});
    endfunction

endpackage

`default_nettype wire

### src/sgpa_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgpa_ram
// Generic single-port-write, registered-read memory.
// ---------------------------------------------------------------------------
`default_nettype none

module sgpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 9216
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/sgpa_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgpa_datapath
// Shared multiplier, basis registers, coefficient memory and result regs.
// ---------------------------------------------------------------------------
`default_nettype none

module sgpa_datapath #(
    parameter int NODE_COUNT = 1024,
    parameter int BAND_COUNT = 9
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sgpa_pkg::cmd_t                  cmd,
    output sgpa_pkg::status_t                    status,
    input  wire logic [sgpa_pkg::IDX_W-1:0]      sample_index,
    input  wire logic signed [sgpa_pkg::SMP_W-1:0] sample_value,
    output logic                                 strobe,
    output logic [sgpa_pkg::IDX_W-1:0]           node_index,
    output logic [sgpa_pkg::BAND_W-1:0]          band_index,
    output logic signed [sgpa_pkg::COEF_W-1:0]  coefficient,
    output logic                                 last_band
);
    import sgpa_pkg::*;

    localparam int DEPTH  = NODE_COUNT * BAND_COUNT;
    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic [IDX_W-1:0]         idx_reg;
    logic signed [SMP_W-1:0]  sample_reg;
    logic signed [20:0]       scaled_reg, a1_reg, t_reg, b2_reg, c2_reg;
    logic signed [17:0]       cc_reg;
    logic signed [15:0]       y_reg;
    logic signed [31:0]       inc_reg;
    logic [ADDR_W-1:0]        clr_addr_reg, clr_addr_next;

    logic                     strobe_reg;
    logic [IDX_W-1:0]         node_reg;
    logic [BAND_W-1:0]        band_reg;
    logic signed [31:0]       coef_reg;
    logic                     last_reg;

    logic signed [20:0] op_a;
    logic signed [17:0] op_b;
    logic               shift8;
    logic signed [38:0] prod;
    logic signed [39:0] rnd;
    logic signed [17:0] st, ct, cp, sp, c2p, s2p;
    logic [4:0]         k, j;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, item_addr;
    logic [31:0]        ram_wdata, ram_rdata;
    logic signed [32:0] sum;
    logic signed [31:0] sum_sat;

    assign k   = idx_reg[4:0];
    assign j   = idx_reg[9:5];
    assign st  = sin_at({1'b0, k});
    assign ct  = sin_at({1'b0, k} + 6'd16);
    assign sp  = sin_at({j, 1'b0});
    assign cp  = sin_at({j, 1'b0} + 6'd16);
    assign s2p = sin_at({j[3:0], 2'b00});
    assign c2p = sin_at({j[3:0], 2'b00} + 6'd16);

    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        shift8 = 1'b0;
        case (cmd.op)
            OP_SCALE:
            begin
                op_a   = 21'(sample_reg);
                op_b   = K_SCALE;
                shift8 = 1'b1;
            end
            OP_A1: begin op_a = K_L1;   op_b = st; end
            OP_B1: begin op_a = K_L2B;  op_b = st; end
            OP_B2: begin op_a = t_reg;  op_b = ct; end
            OP_C1: begin op_a = K_L2A;  op_b = st; end
            OP_C2: begin op_a = t_reg;  op_b = st; end
            OP_CC: begin op_a = 21'(ct); op_b = ct; end
            OP_Y:
            begin
                case (cmd.band)
                    4'd0: begin op_a = K_Y00;  op_b = K_ONE; end
                    4'd1: begin op_a = K_L1;   op_b = ct;    end
                    4'd2: begin op_a = a1_reg; op_b = cp;    end
                    4'd3: begin op_a = a1_reg; op_b = sp;    end
                    4'd4: begin op_a = K_L2A;  op_b = cc_reg; end
                    4'd5: begin op_a = b2_reg; op_b = cp;    end
                    4'd6: begin op_a = b2_reg; op_b = sp;    end
                    4'd7: begin op_a = c2_reg; op_b = c2p;   end
                    4'd8: begin op_a = c2_reg; op_b = s2p;   end
                    default: begin op_a = '0;  op_b = '0;    end
                endcase
            end
            OP_INC: begin op_a = scaled_reg; op_b = 18'(y_reg); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign prod = op_a * op_b;

    // round half up, then arithmetic shift
    always_comb
    begin
        if (shift8)
        begin
            rnd = ($signed({prod[38], prod}) + 40'sd128) >>> 8;
        end
        else
        begin
            rnd = ($signed({prod[38], prod}) + 40'sd8192) >>> 14;
        end
    end

    assign item_addr = ADDR_W'(idx_reg) * ADDR_W'(BAND_COUNT) + ADDR_W'(cmd.band);

    assign sum = {ram_rdata[31], ram_rdata} + {inc_reg[31], inc_reg};
    always_comb
    begin
        if (sum > 33'sh0_7FFF_FFFF)
        begin
            sum_sat = 32'sh7FFF_FFFF;
        end
        else if (sum < -33'sh0_8000_0000)
        begin
            sum_sat = -32'sh8000_0000;
        end
        else
        begin
            sum_sat = sum[31:0];
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = item_addr;
        ram_wdata = sum_sat;
        if (cmd.op == OP_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (cmd.op == OP_ACC)
        begin
            ram_we = 1'b1;
        end
    end

    assign ram_re = (cmd.op == OP_Y);

    sgpa_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (item_addr),
        .rdata (ram_rdata)
    );

    assign clr_addr_next     = clr_addr_reg + ADDR_W'(1);
    assign status.clear_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CLEAR)
            begin
                clr_addr_reg <= clr_addr_next;
            end
            strobe_reg <= (cmd.op == OP_ACC);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                idx_reg    <= sample_index;
                sample_reg <= sample_value;
            end
            OP_SCALE: scaled_reg <= rnd[20:0];
            OP_A1:    a1_reg     <= rnd[20:0];
            OP_B1:    t_reg      <= rnd[20:0];
            OP_B2:    b2_reg     <= rnd[20:0];
            OP_C1:    t_reg      <= rnd[20:0];
            OP_C2:    c2_reg     <= rnd[20:0];
            OP_CC:    cc_reg     <= rnd[17:0] - K_THIRD;
            OP_Y:
            begin
                if (rnd > 40'sd32767)
                begin
                    y_reg <= 16'sh7FFF;
                end
                else if (rnd < -40'sd32768)
                begin
                    y_reg <= -16'sh8000;
                end
                else
                begin
                    y_reg <= rnd[15:0];
                end
            end
            OP_INC:   inc_reg <= rnd[31:0];
            OP_ACC:
            begin
                node_reg <= idx_reg;
                band_reg <= cmd.band;
                coef_reg <= sum_sat;
                last_reg <= cmd.last;
            end
            default:
            begin
            end
        endcase
    end

    assign strobe      = strobe_reg;
    assign node_index  = node_reg;
    assign band_index  = band_reg;
    assign coefficient = coef_reg;
    assign last_band   = last_reg;

endmodule

`default_nettype wire

### src/sgpa_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sgpa_ctrl
// Sequencer: memory clear, basis setup steps, then three steps per band.
// ---------------------------------------------------------------------------
`default_nettype none

module sgpa_ctrl #(
    parameter int NODE_COUNT = 1024,
    parameter int BAND_COUNT = 9
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [sgpa_pkg::IDX_W-1:0]   sample_index,
    input  wire logic [sgpa_pkg::CFG_W-1:0]   active_nodes,
    input  wire sgpa_pkg::status_t            status,
    output sgpa_pkg::cmd_t                    cmd,
    output logic                              busy
);
    import sgpa_pkg::*;

    state_t            state_reg, state_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic              last;
    logic              take;

    assign last = (band_reg == BAND_W'(BAND_COUNT - 1));
    assign take = start && (state_reg == ST_IDLE)
                  && ({1'b0, sample_index} < active_nodes)
                  && ({1'b0, sample_index} < CFG_W'(NODE_COUNT));

    always_comb
    begin
        state_next = state_reg;
        band_next  = band_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_SCALE;
                    band_next  = '0;
                end
            end
            ST_SCALE: state_next = ST_A1;
            ST_A1:    state_next = ST_B1;
            ST_B1:    state_next = ST_B2;
            ST_B2:    state_next = ST_C1;
            ST_C1:    state_next = ST_C2;
            ST_C2:    state_next = ST_CC;
            ST_CC:    state_next = ST_Y;
            ST_Y:     state_next = ST_INC;
            ST_INC:   state_next = ST_ACC;
            ST_ACC:
            begin
                if (last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_Y;
                    band_next  = band_reg + BAND_W'(1);
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.band = band_reg;
        cmd.last = last;
        case (state_reg)
            ST_CLEAR: cmd.op = OP_CLEAR;
            ST_IDLE:  cmd.op = OP_LOAD;
            ST_SCALE: cmd.op = OP_SCALE;
            ST_A1:    cmd.op = OP_A1;
            ST_B1:    cmd.op = OP_B1;
            ST_B2:    cmd.op = OP_B2;
            ST_C1:    cmd.op = OP_C1;
            ST_C2:    cmd.op = OP_C2;
            ST_CC:    cmd.op = OP_CC;
            ST_Y:     cmd.op = OP_Y;
            ST_INC:   cmd.op = OP_INC;
            ST_ACC:   cmd.op = OP_ACC;
            default:  cmd.op = OP_NONE;
        endcase
        busy = (state_reg != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            band_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            band_reg  <= band_next;
        end
    end

endmodule

`default_nettype wire

### src/sh_grid_projection_accumulator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sh_grid_projection_accumulator
// Projects samples onto nine order-2 real spherical harmonics per node and
// accumulates the saturating q16.16 coefficients.
//
//   channel   signals                                          direction
//   request   start, busy, sample_index, sample_value          in (busy out)
//   result    strobe, node_index, band_index, coefficient,
//             last_band                                        out
//   config    psel, penable, pwrite, paddr, pwdata, prdata,
//             pready                                           apb
//
// an accepted request runs the setup steps (scale, a1, b1, b2, c1, c2, cc)
// on the shared multiplier, then per band the basis, increment and
// read-modify-write steps. a dropped index costs nothing.
// after reset the coefficient memory is cleared one word a cycle, busy is
// high until all NODE_COUNT*BAND_COUNT words (9216 by default) are cleared.
// results appear in the cycle after their update and cannot be stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module sh_grid_projection_accumulator #(
    parameter int NODE_COUNT = sgpa_pkg::DEF_NODE_COUNT,
    parameter int BAND_COUNT = sgpa_pkg::DEF_BAND_COUNT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [sgpa_pkg::IDX_W-1:0]        sample_index,
    input  wire logic signed [sgpa_pkg::SMP_W-1:0] sample_value,
    output logic                                   strobe,
    output logic [sgpa_pkg::IDX_W-1:0]             node_index,
    output logic [sgpa_pkg::BAND_W-1:0]            band_index,
    output logic signed [sgpa_pkg::COEF_W-1:0]     coefficient,
    output logic                                   last_band,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import sgpa_pkg::*;

    logic [CFG_W-1:0] active_nodes_reg;
    cmd_t             cmd;
    status_t          status;
    logic             sel_active;

    assign pready     = 1'b1;
    assign sel_active = (paddr[2] == ADDR_ACTIVE_NODES[2]);
    assign prdata     = sel_active ? {21'd0, active_nodes_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_nodes_reg <= CFG_W'(1024);
        end
        else if (psel && penable && pwrite && sel_active)
        begin
            active_nodes_reg <= pwdata[CFG_W-1:0];
        end
    end

    sgpa_ctrl #(
        .NODE_COUNT (NODE_COUNT),
        .BAND_COUNT (BAND_COUNT)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .sample_index (sample_index),
        .active_nodes (active_nodes_reg),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy)
    );

    sgpa_datapath #(
        .NODE_COUNT (NODE_COUNT),
        .BAND_COUNT (BAND_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .sample_index (sample_index),
        .sample_value (sample_value),
        .strobe       (strobe),
        .node_index   (node_index),
        .band_index   (band_index),
        .coefficient  (coefficient),
        .last_band    (last_band)
    );

endmodule

`default_nettype wire
